// ===== rtl/cobs_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cobs_pkg
// Shared constants, transaction types and helpers for the COBS record block
// logger: ring geometry, status codes and the queue slot format.
// ----------------------------------------------------------------------------
package cobs_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int BLOCK_SLOTS = 8;
  localparam int RING_BYTES  = BLOCK_BYTES * BLOCK_SLOTS;
  localparam int OFF_W       = $clog2(BLOCK_BYTES);
  localparam int BLK_W       = $clog2(BLOCK_SLOTS);
  localparam int RING_AW     = $clog2(RING_BYTES);
  localparam int LEN_W       = 12;
  localparam int FREE_W      = $clog2(RING_BYTES + 1);
  localparam int CMP_W       = (FREE_W > LEN_W) ? FREE_W : LEN_W;
  localparam int SEG_MAX     = 254;
  localparam int SEG_AW      = 8;

  localparam logic [7:0] CODE_FULL = 8'hFF;
  localparam logic [7:0] DELIMITER = 8'h00;
  localparam logic       OP_READ   = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_DROPPED   = 2'd1;
  localparam logic [1:0] STAT_REWRITTEN = 2'd2;
  localparam logic [1:0] STAT_EMPTY     = 2'd3;

  typedef struct packed {
    logic             opcode;
    logic [7:0]       data_byte;
    logic             first_of_record;
    logic             last_of_record;
    logic [LEN_W-1:0] record_length;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       block_end;
    logic [1:0] status;
    logic [3:0] ready_count;
  } result_t;

  typedef struct packed {
    logic             is_read;
    logic             is_zero;
    logic [7:0]       data_byte;
    logic             first;
    logic             last;
    logic [LEN_W-1:0] length;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_slot_t;

  function automatic logic [BLK_W-1:0] next_block(input logic [BLK_W-1:0] blk);
    logic [BLK_W-1:0] res;
    if (blk == BLK_W'(BLOCK_SLOTS - 1)) begin
      res = '0;
    end else begin
      res = blk + BLK_W'(1);
    end
    return res;
  endfunction

  function automatic logic [3:0] ready_of(input logic [BLK_W-1:0] full);
    logic [31:0] wide;
    wide = 32'(full);
    return wide[3:0];
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cobs_record_block_logger_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cobs_record_block_logger_unit
// COBS record encoder feeding a ring of fixed-size blocks, with byte-wise
// draining of finished blocks.
//
//   channel   handshake                 payload
//   input     item_valid / item_stall   item   (item_t)
//   output    result_valid / result_stall result (result_t)
//
// A read, a dropped push or a push that only stores a segment byte goes
// straight to the result stage. A push that flushes writes the code byte and
// then the run's bytes, plus a closing code when a zero byte or a full run ends
// the record, and the delimiter at record end; the single ring write port
// moves one encoded byte per cycle.
// Reset is synchronous; no clearing pass, the block takes items at once.
// A two-entry queue keeps accepting while the engine works or a result stalls, until both entries are full.
// ----------------------------------------------------------------------------
module cobs_record_block_logger_unit import cobs_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  item_valid,
  output logic       item_stall,
  input  wire item_t item,
  output logic       result_valid,
  input  wire logic  result_stall,
  output result_t    result
);

  cmd_slot_t head;
  logic      pop;

  cobs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .head       (head),
    .pop        (pop)
  );

  cobs_engine u_engine (
    .clk          (clk),
    .rst          (rst),
    .head         (head),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
`default_nettype wire

// ===== rtl/cobs_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cobs_front
// Accepts input transactions, classifies them into commands and holds them
// in a two-entry queue for the encoding engine.
// ----------------------------------------------------------------------------
module cobs_front import cobs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      item_valid,
  output logic           item_stall,
  input  wire item_t     item,
  output cmd_slot_t      head,
  input  wire logic      pop
);

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  cmd_t       cmd_in;
  logic       push;
  logic       pop_ok;

  always_comb begin
    cmd_in.is_read   = (item.opcode == OP_READ);
    cmd_in.is_zero   = (item.data_byte == 8'd0);
    cmd_in.data_byte = item.data_byte;
    cmd_in.first     = item.first_of_record;
    cmd_in.last      = item.last_of_record;
    cmd_in.length    = item.record_length;
  end

  assign item_stall = (count == 2'd2);
  assign push       = item_valid && !item_stall;
  assign pop_ok     = pop && (count != 2'd0);
  assign head.valid = (count != 2'd0);
  assign head.cmd   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop_ok) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop_ok};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/cobs_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cobs_engine
// Carries out queued commands: segment collection, COBS flushes into the
// block ring, block draining, and the registered result stage.
// ----------------------------------------------------------------------------
module cobs_engine import cobs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire cmd_slot_t head,
  output logic           pop,
  output logic           result_valid,
  input  wire logic      result_stall,
  output result_t        result
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CODE  = 5'b00010,
    S_COPY  = 5'b00100,
    S_DELIM = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  localparam logic [OFF_W-1:0] OFF_LAST  = OFF_W'(BLOCK_BYTES - 1);
  localparam logic [BLK_W-1:0] FULL_LAST = BLK_W'(BLOCK_SLOTS - 1);

  state_t state, state_next;

  logic [7:0]       seg_count, seg_count_next;
  logic [BLK_W-1:0] fill_block, fill_block_next;
  logic [OFF_W-1:0] fill_offset, fill_offset_next;
  logic [BLK_W-1:0] drain_block, drain_block_next;
  logic [OFF_W-1:0] drain_offset, drain_offset_next;
  logic [BLK_W-1:0] full_blocks, full_blocks_next;
  logic             dropping, dropping_next;
  logic             overflow, overflow_next;
  logic [7:0]       copy_idx, copy_idx_next;
  logic [7:0]       copy_len, copy_len_next;
  logic [7:0]       code, code_next;
  logic             last_pend, last_pend_next;
  logic             delim_pend, delim_pend_next;
  logic             res_from_ring, res_from_ring_next;
  logic             res_push_ok, res_push_ok_next;
  logic             res_bend, res_bend_next;
  logic [1:0]       res_status, res_status_next;

  logic [7:0]         ring_mem [RING_BYTES];
  logic [7:0]         ring_rdata;
  logic               ring_re;
  logic [RING_AW-1:0] ring_raddr;
  logic [RING_AW-1:0] ring_waddr;
  logic [7:0]         seg_mem [SEG_MAX];
  logic [7:0]         seg_rdata;
  logic               seg_we;
  logic               seg_re;
  logic [SEG_AW-1:0]  seg_raddr;
  logic [SEG_AW-1:0]  seg_waddr;

  logic             put_en;
  logic [7:0]       put_byte;
  logic [CMP_W-1:0] free_space;
  logic             drop_now;
  logic [7:0]       count_eff;
  logic [7:0]       count_inc;
  logic             load;
  result_t          res_word;

  assign free_space = CMP_W'(BLOCK_BYTES) * (CMP_W'(BLOCK_SLOTS) - CMP_W'(full_blocks))
                      - CMP_W'(fill_offset);
  assign drop_now   = head.cmd.first ? (free_space < CMP_W'(head.cmd.length)) : dropping;
  assign count_eff  = head.cmd.first ? 8'd0 : seg_count;
  assign count_inc  = count_eff + 8'd1;
  assign ring_raddr = RING_AW'(drain_block) * RING_AW'(BLOCK_BYTES) + RING_AW'(drain_offset);
  assign ring_waddr = RING_AW'(fill_block) * RING_AW'(BLOCK_BYTES) + RING_AW'(fill_offset);
  assign seg_waddr  = count_eff;

  always_comb begin
    state_next         = state;
    seg_count_next     = seg_count;
    fill_block_next    = fill_block;
    fill_offset_next   = fill_offset;
    drain_block_next   = drain_block;
    drain_offset_next  = drain_offset;
    full_blocks_next   = full_blocks;
    dropping_next      = dropping;
    overflow_next      = overflow;
    copy_idx_next      = copy_idx;
    copy_len_next      = copy_len;
    code_next          = code;
    last_pend_next     = last_pend;
    delim_pend_next    = delim_pend;
    res_from_ring_next = res_from_ring;
    res_push_ok_next   = res_push_ok;
    res_bend_next      = res_bend;
    res_status_next    = res_status;
    pop                = 1'b0;
    ring_re            = 1'b0;
    seg_we             = 1'b0;
    seg_re             = 1'b0;
    seg_raddr          = copy_idx + 8'd1;
    put_en             = 1'b0;
    put_byte           = code;
    load               = 1'b0;

    case (state)
      S_IDLE: begin
        if (head.valid) begin
          pop           = 1'b1;
          res_bend_next = 1'b0;
          state_next    = S_EMIT;
          if (head.cmd.is_read) begin
            res_push_ok_next = 1'b0;
            if (full_blocks == '0) begin
              res_from_ring_next = 1'b0;
              res_status_next    = STAT_EMPTY;
            end else begin
              ring_re            = 1'b1;
              res_from_ring_next = 1'b1;
              res_status_next    = STAT_OK;
              if (drain_offset == OFF_LAST) begin
                drain_offset_next = '0;
                res_bend_next     = 1'b1;
                drain_block_next  = next_block(drain_block);
                full_blocks_next  = full_blocks - BLK_W'(1);
              end else begin
                drain_offset_next = drain_offset + OFF_W'(1);
              end
            end
          end else begin
            res_from_ring_next = 1'b0;
            dropping_next      = drop_now;
            if (drop_now) begin
              res_push_ok_next = 1'b0;
              res_status_next  = STAT_DROPPED;
            end else begin
              res_push_ok_next = 1'b1;
              res_status_next  = STAT_OK;
              overflow_next    = 1'b0;
              last_pend_next   = 1'b0;
              delim_pend_next  = 1'b0;
              if (head.cmd.is_zero) begin
                code_next      = count_inc;
                copy_len_next  = count_eff;
                seg_count_next = 8'd0;
                last_pend_next = head.cmd.last;
                state_next     = S_CODE;
              end else begin
                seg_we = 1'b1;
                if (count_inc == 8'(SEG_MAX)) begin
                  code_next      = CODE_FULL;
                  copy_len_next  = count_inc;
                  seg_count_next = 8'd0;
                  last_pend_next = head.cmd.last;
                  state_next     = S_CODE;
                end else if (head.cmd.last) begin
                  code_next       = count_inc + 8'd1;
                  copy_len_next   = count_inc;
                  seg_count_next  = 8'd0;
                  delim_pend_next = 1'b1;
                  state_next      = S_CODE;
                end else begin
                  seg_count_next = count_inc;
                end
              end
            end
          end
        end
      end
      S_CODE, S_COPY: begin
        put_en = 1'b1;
        if (state == S_CODE) begin
          put_byte = code;
        end else begin
          put_byte = seg_rdata;
        end
        if ((state == S_CODE) && (copy_len != 8'd0)) begin
          seg_re        = 1'b1;
          seg_raddr     = 8'd0;
          copy_idx_next = 8'd0;
          state_next    = S_COPY;
        end else if ((state == S_COPY) && (copy_idx != copy_len - 8'd1)) begin
          seg_re        = 1'b1;
          copy_idx_next = copy_idx + 8'd1;
        end else if (last_pend) begin
          code_next       = seg_count + 8'd1;
          copy_len_next   = 8'd0;
          last_pend_next  = 1'b0;
          delim_pend_next = 1'b1;
          state_next      = S_CODE;
        end else if (delim_pend) begin
          state_next = S_DELIM;
        end else begin
          state_next = S_EMIT;
        end
      end
      S_DELIM: begin
        put_en          = 1'b1;
        put_byte        = DELIMITER;
        delim_pend_next = 1'b0;
        state_next      = S_EMIT;
      end
      S_EMIT: begin
        if (!result_valid || !result_stall) begin
          load       = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // advance the fill pointer; rewrite the same block when the ring is full
    if (put_en) begin
      if (fill_offset == OFF_LAST) begin
        fill_offset_next = '0;
        if (full_blocks == FULL_LAST) begin
          overflow_next = 1'b1;
        end else begin
          fill_block_next  = next_block(fill_block);
          full_blocks_next = full_blocks + BLK_W'(1);
        end
      end else begin
        fill_offset_next = fill_offset + OFF_W'(1);
      end
    end
  end

  always_comb begin
    res_word.out_byte    = res_from_ring ? ring_rdata : 8'd0;
    res_word.out_valid   = res_from_ring;
    res_word.block_end   = res_bend;
    res_word.status      = res_push_ok ? (overflow ? STAT_REWRITTEN : STAT_OK) : res_status;
    res_word.ready_count = ready_of(full_blocks);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      seg_count    <= 8'd0;
      fill_block   <= '0;
      fill_offset  <= '0;
      drain_block  <= '0;
      drain_offset <= '0;
      full_blocks  <= '0;
      dropping     <= 1'b0;
      overflow     <= 1'b0;
      last_pend    <= 1'b0;
      delim_pend   <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      seg_count    <= seg_count_next;
      fill_block   <= fill_block_next;
      fill_offset  <= fill_offset_next;
      drain_block  <= drain_block_next;
      drain_offset <= drain_offset_next;
      full_blocks  <= full_blocks_next;
      dropping     <= dropping_next;
      overflow     <= overflow_next;
      last_pend    <= last_pend_next;
      delim_pend   <= delim_pend_next;
      if (load) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    copy_idx      <= copy_idx_next;
    copy_len      <= copy_len_next;
    code          <= code_next;
    res_from_ring <= res_from_ring_next;
    res_push_ok   <= res_push_ok_next;
    res_bend      <= res_bend_next;
    res_status    <= res_status_next;
    if (load) begin
      result <= res_word;
    end
  end

  always_ff @(posedge clk) begin
    if (put_en) begin
      ring_mem[ring_waddr] <= put_byte;
    end
    if (ring_re) begin
      ring_rdata <= ring_mem[ring_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (seg_we) begin
      seg_mem[seg_waddr] <= head.cmd.data_byte;
    end
    if (seg_re) begin
      seg_rdata <= seg_mem[seg_raddr];
    end
  end

endmodule
`default_nettype wire

// ===== verif/cobs_record_block_logger_unit_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// cobs_record_block_logger_unit_tb
// Self-checking bench for the COBS record block logger. Record bytes and
// block reads go in, with random gaps on the input side and random stalls on
// the output side. A scoreboard encodes each accepted push into its own copy
// of the block ring and drains it on reads. It checks every result
// transaction in order against that copy.
// ----------------------------------------------------------------------------
module cobs_record_block_logger_unit_tb;
  import cobs_pkg::*;

  localparam logic OP_PUSH     = ~OP_READ;
  localparam int   CYCLE_LIMIT = 4000000;
  localparam int   SETTLE      = 300;
  localparam int   HOLD_CYCLES = 600;

  class ring_logger_scoreboard;
    logic [7:0] ring_mem [RING_BYTES];
    logic [7:0] run_mem [SEG_MAX];
    int         run_len;
    int         fill_blk;
    int         fill_off;
    int         drain_blk;
    int         drain_off;
    int         full_cnt;
    bit         dropping;
    bit         rewrote;
    int         failures;
    result_t    due_results [$];

    function new();
      run_len   = 0;
      fill_blk  = 0;
      fill_off  = 0;
      drain_blk = 0;
      drain_off = 0;
      full_cnt  = 0;
      dropping  = 1'b0;
      rewrote   = 1'b0;
      failures  = 0;
    endfunction

    function void put_byte(logic [7:0] b);
      ring_mem[fill_blk * BLOCK_BYTES + fill_off] = b;
      fill_off++;
      if (fill_off >= BLOCK_BYTES) begin
        fill_off = 0;
        if (full_cnt >= BLOCK_SLOTS - 1) begin
          rewrote = 1'b1;
        end else begin
          fill_blk = (fill_blk + 1) % BLOCK_SLOTS;
          full_cnt++;
        end
      end
    endfunction

    function void flush_run(logic [7:0] code);
      put_byte(code);
      for (int k = 0; k < run_len; k++) begin
        put_byte(run_mem[k]);
      end
      run_len = 0;
    endfunction

    function int free_bytes();
      int blocks;
      blocks = (full_cnt + 1 < BLOCK_SLOTS) ? BLOCK_SLOTS - full_cnt - 1 : 0;
      return blocks * BLOCK_BYTES + (BLOCK_BYTES - fill_off);
    endfunction

    function logic [1:0] take_item(item_t it);
      result_t r;
      r = '0;
      if (it.opcode != OP_READ) begin
        if (it.first_of_record) begin
          if (free_bytes() < int'(it.record_length)) begin
            dropping = 1'b1;
          end else begin
            dropping = 1'b0;
            run_len  = 0;
          end
        end
        if (dropping) begin
          r.status = STAT_DROPPED;
        end else begin
          rewrote = 1'b0;
          if (it.data_byte == DELIMITER) begin
            flush_run(8'(run_len + 1));
          end else begin
            run_mem[run_len] = it.data_byte;
            run_len++;
            if (run_len >= SEG_MAX) begin
              flush_run(CODE_FULL);
            end
          end
          if (it.last_of_record) begin
            flush_run(8'(run_len + 1));
            put_byte(DELIMITER);
          end
          r.status = rewrote ? STAT_REWRITTEN : STAT_OK;
        end
      end else if (full_cnt == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.out_byte  = ring_mem[drain_blk * BLOCK_BYTES + drain_off];
        r.out_valid = 1'b1;
        r.status    = STAT_OK;
        drain_off++;
        if (drain_off >= BLOCK_BYTES) begin
          drain_off   = 0;
          r.block_end = 1'b1;
          drain_blk   = (drain_blk + 1) % BLOCK_SLOTS;
          full_cnt--;
        end
      end
      r.ready_count = 4'(full_cnt);
      due_results.push_back(r);
      return r.status;
    endfunction

    function void check_result(result_t got);
      result_t want;
      bit      same;
      if (due_results.size() == 0) begin
        failures++;
        if (failures <= 10) begin
          $display("unexpected result: byte %02h valid %0d end %0d status %0d ready %0d",
                   got.out_byte, got.out_valid, got.block_end, got.status,
                   got.ready_count);
        end
        return;
      end
      want = due_results.pop_front();
      same = (got.out_byte === want.out_byte) && (got.out_valid === want.out_valid)
          && (got.block_end === want.block_end) && (got.status === want.status)
          && (got.ready_count === want.ready_count);
      if (!same) begin
        failures++;
        if (failures <= 10) begin
          $display("mismatch: expected byte %02h valid %0d end %0d status %0d ready %0d",
                   want.out_byte, want.out_valid, want.block_end, want.status,
                   want.ready_count);
          $display("          actual   byte %02h valid %0d end %0d status %0d ready %0d",
                   got.out_byte, got.out_valid, got.block_end, got.status,
                   got.ready_count);
        end
      end
    endfunction
  endclass

  logic    clk;
  logic    rst;
  logic    item_valid;
  logic    item_stall;
  item_t   item;
  logic    result_valid;
  logic    result_stall;
  result_t result;

  ring_logger_scoreboard ledger;
  int      cycles;
  int      sent;
  int      items_done;
  bit      send_burst;

  cobs_record_block_logger_unit dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .item         (item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && result_valid && !result_stall) begin
      ledger.check_result(result);
    end
  end

  function automatic int pause_len(bit burst);
    int r;
    r = $urandom_range(0, 99);
    if (burst || r < 50) begin
      return 0;
    end else if (r < 85) begin
      return $urandom_range(1, 3);
    end else if (r < 97) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(15, 40);
  endfunction

  function automatic item_t read_item();
    item_t it;
    it                 = item_t'({$urandom, $urandom});
    it.opcode          = OP_READ;
    it.record_length   = 12'($urandom);
    return it;
  endfunction

  function automatic item_t push_item(logic [7:0] b, bit first, bit last, int len);
    item_t it;
    it.opcode          = OP_PUSH;
    it.data_byte       = b;
    it.first_of_record = first;
    it.last_of_record  = last;
    it.record_length   = first ? 12'(len) : 12'($urandom);
    return it;
  endfunction

  task automatic send_item(item_t it);
    int n;
    n = pause_len(send_burst);
    if (n > 0) begin
      @(negedge clk);
      item_valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
    @(negedge clk);
    item_valid = 1'b1;
    item       = it;
    do @(posedge clk); while (item_stall);
    if (ledger.take_item(it) != STAT_DROPPED) begin
      items_done++;
    end
    sent++;
    if (sent % 64 == 0) begin
      send_burst = ($urandom_range(0, 3) == 0);
    end
  endtask

  task automatic send_record(int read_pct, bit allow_long);
    logic [7:0] body [$];
    int         kind;
    int         n;
    int         declared;
    bit         with_first;
    bit         with_last;
    body       = {};
    with_first = 1'b1;
    with_last  = 1'b1;
    kind       = $urandom_range(0, 99);
    if (kind < 60) begin
      n = $urandom_range(1, 40);
      repeat (n) body.push_back(($urandom_range(0, 4) == 0) ? DELIMITER
                                                            : 8'($urandom_range(1, 255)));
    end else if (kind < 72 && allow_long) begin
      case ($urandom_range(0, 4))
        0: n = SEG_MAX - 1;
        1: n = SEG_MAX;
        2: n = SEG_MAX + 1;
        3: n = 2 * SEG_MAX;
        default: n = $urandom_range(200, 320);
      endcase
      repeat (n) body.push_back(8'($urandom_range(1, 255)));
      if ($urandom_range(0, 2) == 0) begin
        body.push_back(DELIMITER);
      end
    end else if (kind < 80) begin
      n = $urandom_range(1, 6);
      repeat (n) body.push_back(DELIMITER);
    end else begin
      // broken record: random bytes, sometimes with missing start or missing end
      n = $urandom_range(1, 20);
      repeat (n) body.push_back(8'($urandom));
      case ($urandom_range(0, 2))
        0: with_first = 1'b0;
        1: with_last = 1'b0;
        default: ;
      endcase
    end
    declared = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 4095) : body.size();
    for (int i = 0; i < body.size(); i++) begin
      while ($urandom_range(0, 99) < read_pct) send_item(read_item());
      send_item(push_item(body[i], with_first && i == 0,
                          with_last && i == body.size() - 1, declared));
    end
  endtask

  initial begin
    int  n;
    int  elapsed;
    int  hold_at;
    bit  held;
    bit  take_burst;
    elapsed      = 0;
    held         = 1'b0;
    take_burst   = 1'b0;
    hold_at      = $urandom_range(400, 900);
    result_stall = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      if (!held && elapsed >= hold_at) begin
        // hold off long enough for the block to back up into its input
        result_stall = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        elapsed += HOLD_CYCLES;
        held = 1'b1;
      end else begin
        n = pause_len(take_burst);
        if (n > 0) begin
          result_stall = 1'b1;
          repeat (n) @(negedge clk);
          elapsed += n;
        end
      end
      result_stall = 1'b0;
      n = $urandom_range(1, 8);
      repeat (n) @(negedge clk);
      elapsed += n;
      if ($urandom_range(0, 15) == 0) begin
        take_burst = ~take_burst;
      end
    end
  end

  initial begin
    ledger     = new();
    cycles     = 0;
    sent       = 0;
    items_done = 0;
    send_burst = 1'b0;
    rst        = 1'b1;
    item_valid = 1'b0;
    item       = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_item(item_t'('1));
    send_item(read_item());
    send_item(push_item(8'h00, 1'b0, 1'b0, 0));
    send_item(push_item(8'hFF, 1'b0, 1'b1, 0));
    send_item(push_item(8'h00, 1'b1, 1'b1, 1));
    send_item(push_item(8'hFF, 1'b1, 1'b1, 4095));
    send_item(push_item(8'h01, 1'b1, 1'b0, 3));
    send_item(push_item(8'h80, 1'b0, 1'b0, 0));
    send_item(push_item(8'h7F, 1'b1, 1'b0, 2));
    send_item(push_item(8'h00, 1'b0, 1'b1, 0));
    send_item(push_item(8'h00, 1'b1, 1'b0, 5));
    send_item(push_item(8'h00, 1'b0, 1'b0, 0));
    send_item(push_item(8'hAA, 1'b0, 1'b0, 0));
    send_item(push_item(8'h00, 1'b0, 1'b0, 0));
    send_item(push_item(8'h55, 1'b0, 1'b1, 0));
    send_item(read_item());
    send_item(push_item(8'h01, 1'b1, 1'b1, 2048));

    while (items_done < 1500) send_record(35, 1'b1);
    repeat (4) send_item(read_item());

    @(negedge clk);
    item_valid = 1'b0;
    while (ledger.due_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (ledger.failures == 0 && ledger.due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
`default_nettype wire
